// File: hdl/bsm_pkg.sv
// Package: shared constants, types and codes for the background subtraction block
`timescale 1ns / 1ps
package bsm_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MASK_RING  = 2 * MAX_WIDTH + 4;
    localparam int PIX_RING   = 4 * MAX_WIDTH + 8;
    localparam int BG_DEPTH   = MAX_WIDTH * MAX_HEIGHT;

    localparam int CFG_BITS   = 11;
    localparam int WW_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int HW_BITS    = $clog2(MAX_HEIGHT + 1);
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int POS_BITS   = $clog2(BG_DEPTH + 1);
    localparam int SUM_BITS   = POS_BITS + 1;
    localparam int BG_AW      = $clog2(BG_DEPTH);
    localparam int MIDX_BITS  = $clog2(MASK_RING);
    localparam int PIDX_BITS  = $clog2(PIX_RING);
    localparam int MASK_AW    = MIDX_BITS + 2;
    localparam int PADDR_BITS = 4;

    localparam logic [7:0] LUM_R = 8'd77;
    localparam logic [7:0] LUM_G = 8'd150;
    localparam logic [7:0] LUM_B = 8'd29;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_BLEND_RATE,
        REG_MOTION_THRESHOLD
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIX,
        ST_BG,
        ST_BLEND,
        ST_CHECK,
        ST_SCHED,
        ST_WIN,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        valid;
        logic        learn;
        logic [15:0] lum;
        logic [15:0] bg_old;
        logic [15:0] alpha;
        logic [15:0] thr;
    } blend_req_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] bg_new;
        logic        fg;
    } blend_res_t;
endpackage

// File: hdl/bsm_if.sv
// Interfaces: pixel input channel and result output channel
`timescale 1ns / 1ps
interface bsm_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface bsm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       is_foreground;
    logic       frame_end;
    modport source (output valid, red_out, green_out, blue_out, is_foreground, frame_end,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, is_foreground, frame_end,
                  output ready);
endinterface

// File: hdl/bsm_ram.sv
// Generic simple dual-port RAM with registered read data
`timescale 1ns / 1ps
module bsm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hdl/bsm_blend.sv
// Background blend pipeline: running average update (luminance copied while learning) and foreground threshold
`timescale 1ns / 1ps
module bsm_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  bsm_pkg::blend_req_t req,
    output bsm_pkg::blend_res_t res
);
    logic        v1_reg, v2_reg;
    logic [32:0] p1_reg;
    logic [31:0] p2_reg;
    logic [15:0] lum1_reg, lum2_reg, thr1_reg, thr2_reg, bg_reg;
    logic        learn1_reg;
    logic [33:0] sum;
    logic [15:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
        end
    end

    assign sum = 34'(p1_reg) + 34'(p2_reg) + 34'd32768;

    always_ff @(posedge clk)
    begin
        p1_reg     <= 33'(req.bg_old) * (33'd65536 - 33'(req.alpha));
        p2_reg     <= 32'(req.lum) * 32'(req.alpha);
        lum1_reg   <= req.lum;
        thr1_reg   <= req.thr;
        learn1_reg <= req.learn;
        lum2_reg   <= lum1_reg;
        thr2_reg   <= thr1_reg;
        bg_reg     <= learn1_reg ? lum1_reg : sum[31:16];
    end

    assign diff       = (lum2_reg > bg_reg) ? lum2_reg - bg_reg : bg_reg - lum2_reg;
    assign res.valid  = v2_reg;
    assign res.bg_new = bg_reg;
    assign res.fg     = diff > thr2_reg;
endmodule

// File: hdl/background_subtract_morph_mask.sv
// Top level: background subtraction with a 3x3 morphology cleaned motion mask
//
// channel   dir  handshake          contents
// pix_in    in   valid/ready        mode, red_in, green_in, blue_in
// pix_out   out  valid/ready        red_out, green_out, blue_out, is_foreground, frame_end
// apb       in   psel/penable       frame_width, frame_height, blend_rate, motion_threshold
//
// One transaction at a time. A pixel write passes through a background read and two blend stages.
// Each 3x3 window makes nine reads through the single mask memory read port.
// A result needs about four windows in steady state.
// No clearing pass after reset; learning restarts after reset and after a size write.
// A result waits in the output register; a new transaction is taken meanwhile.
`timescale 1ns / 1ps
module background_subtract_morph_mask (
    input  logic                           clk,
    input  logic                           rst_n,
    bsm_in_if.sink                         pix_in,
    bsm_out_if.source                      pix_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsm_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    localparam int PB = bsm_pkg::POS_BITS;
    localparam int SB = bsm_pkg::SUM_BITS;
    localparam int MB = bsm_pkg::MIDX_BITS;
    localparam int QB = bsm_pkg::PIDX_BITS;
    localparam int XB = bsm_pkg::X_BITS;
    localparam int YB = bsm_pkg::Y_BITS;
    localparam int WB = bsm_pkg::WW_BITS;
    localparam int HB = bsm_pkg::HW_BITS;

    bsm_pkg::state_t state_reg, state_next;

    logic [bsm_pkg::CFG_BITS-1:0] fw_reg, fh_reg;
    logic [15:0] alpha_reg, thr_reg;
    logic        learn_reg;
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [PB-1:0] n_reg;

    logic       mode_reg;
    logic [7:0] red_reg, grn_reg, blu_reg;

    logic [PB-1:0] r_pos_reg;
    logic [MB-1:0] r_midx_reg;
    logic [QB-1:0] r_pidx_reg;
    logic [PB-1:0] cur_pos_reg  [4];
    logic [XB-1:0] cur_x_reg    [4];
    logic [YB-1:0] cur_y_reg    [4];
    logic [MB-1:0] cur_midx_reg [4];
    logic [QB-1:0] o_pidx_reg;

    logic [1:0]    k_reg, sel;
    logic [3:0]    j_reg;
    logic          acc_reg, ok_reg, erode_reg;
    logic [XB-1:0] wx_reg;
    logic [YB-1:0] wy_reg;
    logic [MB-1:0] widx_reg;
    logic [PB-1:0] target_reg;

    logic          out_valid_reg, out_fg_reg, out_end_reg;
    logic [7:0]    out_r_reg, out_g_reg, out_b_reg;

    logic          cfg_wr, out_free, clear_cnt, emit_go, last_out;
    logic          pix_ok, out_ok;
    logic [SB-1:0] need1, need2, tgt;
    logic [15:0]   lum;
    logic [1:0]    dyc, dxc;
    logic          nb_ok, bit_in, acc_next;
    logic [MB:0]   row, col;

    logic          bg_re, bg_we, mk_re, mk_we, px_re, px_we;
    logic [bsm_pkg::MASK_AW-1:0] mk_raddr, mk_waddr;
    logic          mk_wdata, mk_rdata;
    logic [15:0]   bg_rdata;
    logic [23:0]   px_rdata;

    bsm_pkg::blend_req_t blend_req;
    bsm_pkg::blend_res_t blend_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (bsm_pkg::reg_idx_t'(paddr[3:2]))
            bsm_pkg::REG_FRAME_WIDTH:      prdata = 32'(fw_reg);
            bsm_pkg::REG_FRAME_HEIGHT:     prdata = 32'(fh_reg);
            bsm_pkg::REG_BLEND_RATE:       prdata = 32'(alpha_reg);
            bsm_pkg::REG_MOTION_THRESHOLD: prdata = 32'(thr_reg);
            default:                       prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = WB'(1);
        else if (32'(fw_reg) > bsm_pkg::MAX_WIDTH)
            w_eff = WB'(bsm_pkg::MAX_WIDTH);
        else
            w_eff = WB'(fw_reg);
        if (fh_reg == '0)
            h_eff = HB'(1);
        else if (32'(fh_reg) > bsm_pkg::MAX_HEIGHT)
            h_eff = HB'(bsm_pkg::MAX_HEIGHT);
        else
            h_eff = HB'(fh_reg);
    end

    assign lum = 16'(red_reg) * 16'(bsm_pkg::LUM_R) + 16'(grn_reg) * 16'(bsm_pkg::LUM_G)
               + 16'(blu_reg) * 16'(bsm_pkg::LUM_B);

    assign pix_ok = !mode_reg && (r_pos_reg < n_reg);
    assign out_ok = (cur_pos_reg[3] < n_reg) && ((r_pos_reg == n_reg) ||
                    (SB'(r_pos_reg) >= SB'(cur_pos_reg[3]) + (SB'(w_eff) << 2) + SB'(5)));
    assign tgt    = SB'(cur_pos_reg[3]) + SB'(w_eff) + SB'(2);

    // stage scheduler: lower stages are pulled before a higher one advances
    always_comb
    begin
        need2 = SB'(cur_pos_reg[2]) + SB'(w_eff) + SB'(2);
        if (need2 > SB'(n_reg))
            need2 = SB'(n_reg);
        need1 = SB'(cur_pos_reg[1]) + SB'(w_eff) + SB'(2);
        if (need1 > SB'(n_reg))
            need1 = SB'(n_reg);
        if (cur_pos_reg[2] < target_reg)
        begin
            if (SB'(cur_pos_reg[1]) < need2)
                sel = (SB'(cur_pos_reg[0]) < need1) ? 2'd0 : 2'd1;
            else
                sel = 2'd2;
        end
        else
            sel = 2'd3;
    end

    // neighbor address and frame bounds
    always_comb
    begin
        dyc = (j_reg < 4'd3) ? 2'd0 : ((j_reg < 4'd6) ? 2'd1 : 2'd2);
        case (j_reg)
            4'd0, 4'd3, 4'd6: dxc = 2'd0;
            4'd1, 4'd4, 4'd7: dxc = 2'd1;
            default:          dxc = 2'd2;
        endcase
        nb_ok = 1'b1;
        if (dyc == 2'd0 && wy_reg == '0)
            nb_ok = 1'b0;
        if (dyc == 2'd2 && HB'(wy_reg) + HB'(1) >= h_eff)
            nb_ok = 1'b0;
        if (dxc == 2'd0 && wx_reg == '0)
            nb_ok = 1'b0;
        if (dxc == 2'd2 && WB'(wx_reg) + WB'(1) >= w_eff)
            nb_ok = 1'b0;
        row = (MB + 1)'(widx_reg);
        if (dyc == 2'd0)
            row = ((MB + 1)'(widx_reg) >= (MB + 1)'(w_eff))
                ? (MB + 1)'(widx_reg) - (MB + 1)'(w_eff)
                : (MB + 1)'(widx_reg) + (MB + 1)'(bsm_pkg::MASK_RING) - (MB + 1)'(w_eff);
        else if (dyc == 2'd2)
        begin
            row = (MB + 1)'(widx_reg) + (MB + 1)'(w_eff);
            if (row >= (MB + 1)'(bsm_pkg::MASK_RING))
                row = row - (MB + 1)'(bsm_pkg::MASK_RING);
        end
        col = row;
        if (dxc == 2'd0)
            col = (row == '0) ? (MB + 1)'(bsm_pkg::MASK_RING - 1) : row - (MB + 1)'(1);
        else if (dxc == 2'd2)
            col = (row == (MB + 1)'(bsm_pkg::MASK_RING - 1)) ? '0 : row + (MB + 1)'(1);
    end

    assign bit_in   = ok_reg ? mk_rdata : erode_reg;
    assign acc_next = erode_reg ? (acc_reg & bit_in) : (acc_reg | bit_in);

    assign out_free = !out_valid_reg || pix_out.ready;
    assign emit_go  = (state_reg == bsm_pkg::ST_EMIT) && out_free;
    assign last_out = (cur_pos_reg[3] + PB'(1)) == n_reg;
    assign clear_cnt = (cfg_wr && (paddr[3:2] == bsm_pkg::REG_FRAME_WIDTH ||
                                   paddr[3:2] == bsm_pkg::REG_FRAME_HEIGHT))
                       || (emit_go && last_out);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsm_pkg::ST_IDLE:
                if (pix_in.valid)
                    state_next = bsm_pkg::ST_PIX;
            bsm_pkg::ST_PIX:
                state_next = pix_ok ? bsm_pkg::ST_BG : bsm_pkg::ST_CHECK;
            bsm_pkg::ST_BG:
                state_next = bsm_pkg::ST_BLEND;
            bsm_pkg::ST_BLEND:
                if (blend_res.valid)
                    state_next = bsm_pkg::ST_CHECK;
            bsm_pkg::ST_CHECK:
                state_next = out_ok ? bsm_pkg::ST_SCHED : bsm_pkg::ST_IDLE;
            bsm_pkg::ST_SCHED:
                state_next = bsm_pkg::ST_WIN;
            bsm_pkg::ST_WIN:
                if (j_reg == 4'd9)
                    state_next = bsm_pkg::ST_FIN;
            bsm_pkg::ST_FIN:
                state_next = (k_reg == 2'd3) ? bsm_pkg::ST_EMIT : bsm_pkg::ST_SCHED;
            bsm_pkg::ST_EMIT:
                if (out_free)
                    state_next = bsm_pkg::ST_IDLE;
            default:
                state_next = bsm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pix_in.ready = 1'b0;
        bg_re = 1'b0;
        bg_we = 1'b0;
        px_re = 1'b0;
        px_we = 1'b0;
        mk_re = 1'b0;
        mk_we = 1'b0;
        mk_waddr = {2'd0, r_midx_reg};
        mk_wdata = blend_res.fg;
        mk_raddr = {k_reg, col[MB-1:0]};
        blend_req.valid  = 1'b0;
        blend_req.learn  = learn_reg;
        blend_req.lum    = lum;
        blend_req.bg_old = bg_rdata;
        blend_req.alpha  = alpha_reg;
        blend_req.thr    = thr_reg;
        unique case (state_reg)
            bsm_pkg::ST_IDLE:  pix_in.ready = 1'b1;
            bsm_pkg::ST_PIX:   bg_re = pix_ok;
            bsm_pkg::ST_BG:    blend_req.valid = 1'b1;
            bsm_pkg::ST_BLEND:
            begin
                bg_we = blend_res.valid;
                px_we = blend_res.valid;
                mk_we = blend_res.valid;
            end
            bsm_pkg::ST_SCHED: px_re = (sel == 2'd3);
            bsm_pkg::ST_WIN:   mk_re = (j_reg != 4'd9);
            bsm_pkg::ST_FIN:
            begin
                mk_we    = (k_reg != 2'd3);
                mk_waddr = {k_reg + 2'd1, widx_reg};
                mk_wdata = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsm_pkg::ST_IDLE;
            fw_reg        <= bsm_pkg::CFG_BITS'(640);
            fh_reg        <= bsm_pkg::CFG_BITS'(480);
            alpha_reg     <= 16'd3277;
            thr_reg       <= 16'd5120;
            learn_reg     <= 1'b1;
            n_reg         <= '0;
            r_pos_reg     <= '0;
            r_midx_reg    <= '0;
            r_pidx_reg    <= '0;
            o_pidx_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                cur_pos_reg[i]  <= '0;
                cur_x_reg[i]    <= '0;
                cur_y_reg[i]    <= '0;
                cur_midx_reg[i] <= '0;
            end
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= PB'(w_eff) * PB'(h_eff);
            if (cfg_wr)
            begin
                unique case (bsm_pkg::reg_idx_t'(paddr[3:2]))
                    bsm_pkg::REG_FRAME_WIDTH:
                    begin
                        fw_reg    <= pwdata[bsm_pkg::CFG_BITS-1:0];
                        learn_reg <= 1'b1;
                    end
                    bsm_pkg::REG_FRAME_HEIGHT:
                    begin
                        fh_reg    <= pwdata[bsm_pkg::CFG_BITS-1:0];
                        learn_reg <= 1'b1;
                    end
                    bsm_pkg::REG_BLEND_RATE:       alpha_reg <= pwdata[15:0];
                    bsm_pkg::REG_MOTION_THRESHOLD: thr_reg   <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == bsm_pkg::ST_BLEND && blend_res.valid)
            begin
                r_pos_reg  <= r_pos_reg + PB'(1);
                r_midx_reg <= (r_midx_reg == MB'(bsm_pkg::MASK_RING - 1))
                            ? '0 : r_midx_reg + MB'(1);
                r_pidx_reg <= (r_pidx_reg == QB'(bsm_pkg::PIX_RING - 1))
                            ? '0 : r_pidx_reg + QB'(1);
                if (r_pos_reg + PB'(1) == n_reg)
                    learn_reg <= 1'b0;
            end
            if (state_reg == bsm_pkg::ST_SCHED)
            begin
                k_reg <= sel;
                j_reg <= '0;
            end
            if (state_reg == bsm_pkg::ST_WIN)
                j_reg <= j_reg + 4'd1;
            if ((state_reg == bsm_pkg::ST_FIN && k_reg != 2'd3) || emit_go)
            begin
                cur_pos_reg[k_reg]  <= cur_pos_reg[k_reg] + PB'(1);
                cur_midx_reg[k_reg] <= (cur_midx_reg[k_reg] == MB'(bsm_pkg::MASK_RING - 1))
                                     ? '0 : cur_midx_reg[k_reg] + MB'(1);
                if (WB'(cur_x_reg[k_reg]) + WB'(1) == w_eff)
                begin
                    cur_x_reg[k_reg] <= '0;
                    cur_y_reg[k_reg] <= cur_y_reg[k_reg] + YB'(1);
                end
                else
                    cur_x_reg[k_reg] <= cur_x_reg[k_reg] + XB'(1);
            end
            if (emit_go)
                o_pidx_reg <= (o_pidx_reg == QB'(bsm_pkg::PIX_RING - 1))
                            ? '0 : o_pidx_reg + QB'(1);
            if (pix_out.ready)
                out_valid_reg <= 1'b0;
            if (emit_go)
                out_valid_reg <= 1'b1;
            if (clear_cnt)
            begin
                r_pos_reg  <= '0;
                r_midx_reg <= '0;
                r_pidx_reg <= '0;
                o_pidx_reg <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    cur_pos_reg[i]  <= '0;
                    cur_x_reg[i]    <= '0;
                    cur_y_reg[i]    <= '0;
                    cur_midx_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && pix_in.ready)
        begin
            mode_reg <= pix_in.mode;
            red_reg  <= pix_in.red_in;
            grn_reg  <= pix_in.green_in;
            blu_reg  <= pix_in.blue_in;
        end
        if (state_reg == bsm_pkg::ST_CHECK)
            target_reg <= (tgt > SB'(n_reg)) ? n_reg : PB'(tgt);
        if (state_reg == bsm_pkg::ST_SCHED)
        begin
            wx_reg    <= cur_x_reg[sel];
            wy_reg    <= cur_y_reg[sel];
            widx_reg  <= cur_midx_reg[sel];
            erode_reg <= (sel == 2'd0) || (sel == 2'd3);
            acc_reg   <= (sel == 2'd0) || (sel == 2'd3);
        end
        if (state_reg == bsm_pkg::ST_WIN)
        begin
            ok_reg <= nb_ok;
            if (j_reg != 4'd0)
                acc_reg <= acc_next;
        end
        if (emit_go)
        begin
            out_fg_reg  <= acc_reg;
            out_end_reg <= last_out;
            out_r_reg   <= acc_reg ? 8'd255 : px_rdata[23:16];
            out_g_reg   <= acc_reg ? 8'd0 : px_rdata[15:8];
            out_b_reg   <= acc_reg ? 8'd0 : px_rdata[7:0];
        end
    end

    assign pix_out.valid         = out_valid_reg;
    assign pix_out.red_out       = out_r_reg;
    assign pix_out.green_out     = out_g_reg;
    assign pix_out.blue_out      = out_b_reg;
    assign pix_out.is_foreground = out_fg_reg;
    assign pix_out.frame_end     = out_end_reg;

    bsm_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .res   (blend_res)
    );

    bsm_ram #(.DEPTH(bsm_pkg::BG_DEPTH), .WIDTH(16)) u_bg_ram (
        .clk   (clk),
        .we    (bg_we),
        .waddr (r_pos_reg[bsm_pkg::BG_AW-1:0]),
        .wdata (blend_res.bg_new),
        .re    (bg_re),
        .raddr (r_pos_reg[bsm_pkg::BG_AW-1:0]),
        .rdata (bg_rdata)
    );

    bsm_ram #(.DEPTH(4 << bsm_pkg::MIDX_BITS), .WIDTH(1)) u_mask_ram (
        .clk   (clk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .re    (mk_re),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    bsm_ram #(.DEPTH(bsm_pkg::PIX_RING), .WIDTH(24)) u_pix_ram (
        .clk   (clk),
        .we    (px_we),
        .waddr (r_pidx_reg),
        .wdata ({red_reg, grn_reg, blu_reg}),
        .re    (px_re),
        .raddr (o_pidx_reg),
        .rdata (px_rdata)
    );

    a_cursor_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_pos_reg[0] >= cur_pos_reg[1]) && (cur_pos_reg[1] >= cur_pos_reg[2])
        && (cur_pos_reg[2] >= cur_pos_reg[3]))
        else $error("stage cursors out of order");

    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bsm_pkg::ST_IDLE) |-> (r_pos_reg <= n_reg))
        else $error("pixel count beyond frame size");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bsm_pkg::ST_EMIT))
        else $error("result appeared outside emit");

    a_blend_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        blend_res.valid |-> (state_reg == bsm_pkg::ST_BLEND))
        else $error("blend result outside blend wait");
endmodule

// File: sim/background_subtract_morph_mask_tb.sv
// Testbench: background subtraction block checked against a pixel-accurate predictor
`timescale 1ns / 1ps
module background_subtract_morph_mask_tb;
    localparam int SETTLE      = 400;
    localparam int STALL_LIMIT = 200000;
    localparam int LONG_HOLD   = 500;
    localparam bit MODE_PIXEL  = 1'b0;
    localparam bit MODE_DRAIN  = 1'b1;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fg;
        logic       last;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [bsm_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bsm_in_if  pix_in_bus ();
    bsm_out_if pix_out_bus ();

    background_subtract_morph_mask i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [10:0] width_reg = 11'd640;
    logic [10:0] height_reg = 11'd480;
    logic [15:0] alpha_reg = 16'd3277;
    logic [15:0] thresh_reg = 16'd5120;
    bit          learning = 1'b1;
    int          pixels_in = 0;
    int          results_out = 0;
    int          cur_w;
    int          cur_h;
    bit [15:0]   bg_model [bsm_pkg::BG_DEPTH];
    bit          raw_mask [bsm_pkg::BG_DEPTH];
    bit [23:0]   frame_pixels [bsm_pkg::BG_DEPTH];

    pixel_result_t expected_pixels[$];
    int  errors = 0;
    int  items_sent = 0;
    int  frame_no = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;

    function automatic int clamp_size(logic [10:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic bit morph_bit(int k, int q);
        int  x;
        int  y;
        int  xx;
        int  yy;
        bit  v;
        bit  b;
        bit  ero;
        if (k == 0)
            return raw_mask[q];
        ero = (k == 1 || k == 4);
        v = ero;
        x = q % cur_w;
        y = q / cur_w;
        for (int dy = -1; dy <= 1; dy++)
        begin
            yy = y + dy;
            if (yy < 0 || yy >= cur_h)
                continue;
            for (int dx = -1; dx <= 1; dx++)
            begin
                xx = x + dx;
                if (xx < 0 || xx >= cur_w)
                    continue;
                b = morph_bit(k - 1, yy * cur_w + xx);
                v = ero ? (v & b) : (v | b);
            end
        end
        return v;
    endfunction

    function automatic void predict_item(bit mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int            n;
        int            lum;
        longint        acc;
        int            bgv;
        int            diff;
        pixel_result_t res;
        cur_w = clamp_size(width_reg, bsm_pkg::MAX_WIDTH);
        cur_h = clamp_size(height_reg, bsm_pkg::MAX_HEIGHT);
        n = cur_w * cur_h;
        if (mode == MODE_PIXEL && pixels_in < n)
        begin
            lum = 77 * r + 150 * g + 29 * b;
            if (learning)
                bgv = lum;
            else
            begin
                acc = longint'(bg_model[pixels_in]) * (65536 - alpha_reg)
                    + longint'(lum) * alpha_reg + 32768;
                bgv = int'(acc >> 16);
            end
            bg_model[pixels_in] = bgv[15:0];
            diff = (lum > bgv) ? lum - bgv : bgv - lum;
            raw_mask[pixels_in] = (diff > thresh_reg);
            frame_pixels[pixels_in] = {r, g, b};
            pixels_in++;
            if (pixels_in == n)
                learning = 1'b0;
        end
        if (results_out >= n || !(pixels_in == n || pixels_in >= results_out + 4 * cur_w + 5))
            return;
        res.fg = morph_bit(4, results_out);
        res.red = res.fg ? 8'd255 : frame_pixels[results_out][23:16];
        res.green = res.fg ? 8'd0 : frame_pixels[results_out][15:8];
        res.blue = res.fg ? 8'd0 : frame_pixels[results_out][7:0];
        res.last = (results_out + 1 == n);
        expected_pixels.push_back(res);
        results_out++;
        if (results_out == n)
        begin
            pixels_in = 0;
            results_out = 0;
        end
    endfunction

    task automatic send_item(bit mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            pix_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_bus.valid <= 1'b1;
        pix_in_bus.mode <= mode;
        pix_in_bus.red_in <= r;
        pix_in_bus.green_in <= g;
        pix_in_bus.blue_in <= b;
        do
            @(posedge clk);
        while (!pix_in_bus.ready);
        predict_item(mode, r, g, b);
        items_sent++;
    endtask

    task automatic write_reg(bsm_pkg::reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bsm_pkg::PADDR_BITS'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bsm_pkg::REG_FRAME_WIDTH, bsm_pkg::REG_FRAME_HEIGHT:
            begin
                if (idx == bsm_pkg::REG_FRAME_WIDTH)
                    width_reg = value[10:0];
                else
                    height_reg = value[10:0];
                learning = 1'b1;
                pixels_in = 0;
                results_out = 0;
            end
            bsm_pkg::REG_BLEND_RATE:
                alpha_reg = value[15:0];
            default:
                thresh_reg = value[15:0];
        endcase
    endtask

    task automatic wait_idle();
        pix_in_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_frame(int w, int h, int alpha, int thr);
        write_reg(bsm_pkg::REG_FRAME_WIDTH, w);
        write_reg(bsm_pkg::REG_FRAME_HEIGHT, h);
        write_reg(bsm_pkg::REG_BLEND_RATE, alpha);
        write_reg(bsm_pkg::REG_MOTION_THRESHOLD, thr);
    endtask

    task automatic scene_pixel(int pos, bit noise);
        int          w;
        int          x;
        logic [7:0]  base;
        w = clamp_size(width_reg, bsm_pkg::MAX_WIDTH);
        x = pos % w;
        base = 8'(40 + 16 * ((pos / w) % 4));
        if (noise || $urandom_range(0, 7) == 0)
            send_item(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (x >= frame_no % w && x <= frame_no % w + 1)
            send_item(MODE_PIXEL, 8'(200 + $urandom_range(0, 55)), 8'($urandom_range(150, 255)),
                      8'($urandom));
        else
            send_item(MODE_PIXEL, base + 8'($urandom_range(0, 3)), base, base + 8'd2);
    endtask

    // completes the frame in progress; the tail is flushed by drains or pixels acting as drains
    task automatic finish_frame();
        int n;
        n = clamp_size(width_reg, bsm_pkg::MAX_WIDTH) * clamp_size(height_reg, bsm_pkg::MAX_HEIGHT);
        while (pixels_in > 0)
        begin
            if (pixels_in < n)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(MODE_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    scene_pixel(pixels_in, 1'b0);
            end
            else if ($urandom_range(0, 3) == 0)
                send_item(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_item(MODE_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        frame_no++;
    endtask

    task automatic full_frame();
        scene_pixel(0, 1'b0);
        finish_frame();
    endtask

    task automatic test_directed();
        set_frame(4, 3, 65535, 0);
        send_item(MODE_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_PIXEL, 8'd0, 8'd0, 8'd0);
        send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
        send_item(MODE_DRAIN, 8'd0, 8'd0, 8'd0);
        send_item(MODE_PIXEL, 8'd255, 8'd0, 8'd0);
        send_item(MODE_PIXEL, 8'd0, 8'd255, 8'd0);
        send_item(MODE_PIXEL, 8'd0, 8'd0, 8'd255);
        for (int i = 5; i < 12; i++)
            send_item(MODE_PIXEL, 8'(i * 37), 8'(i * 91), 8'(i * 13));
        send_item(MODE_PIXEL, 8'hAA, 8'h55, 8'hAA);
        while (pixels_in > 0)
            send_item(MODE_DRAIN, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 12; i++)
            send_item(MODE_PIXEL, (i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd255 : 8'd0, 8'(i * 20));
        while (pixels_in > 0)
            send_item(MODE_DRAIN, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(bsm_pkg::REG_MOTION_THRESHOLD, 65280);
        write_reg(bsm_pkg::REG_BLEND_RATE, 0);
        full_frame();
        wait_idle();
    endtask

    task automatic test_size_extremes();
        set_frame(0, 5, 3277, 100);
        full_frame();
        full_frame();
        wait_idle();
        set_frame(2047, 1, 20000, 500);
        repeat (6) scene_pixel(pixels_in, 1'b1);
        wait_idle();
        set_frame(1, 2047, 1, 500);
        full_frame();
        wait_idle();
    endtask

    task automatic test_midframe_resize();
        set_frame(5, 4, 30000, 300);
        for (int i = 0; i < 7; i++)
            scene_pixel(i, 1'b1);
        wait_idle();
        write_reg(bsm_pkg::REG_FRAME_HEIGHT, 4);
        full_frame();
        for (int i = 0; i < 18; i++)
            scene_pixel(i, 1'b0);
        wait_idle();
        write_reg(bsm_pkg::REG_FRAME_WIDTH, 6);
        full_frame();
        full_frame();
        wait_idle();
    endtask

    task automatic test_random();
        int start;
        int phase;
        start = items_sent;
        phase = 0;
        while (items_sent - start < 450 || phase < 4)
        begin
            set_frame($urandom_range(1, 12), $urandom_range(1, 8),
                      ($urandom_range(0, 4) == 0) ? 65535 * $urandom_range(0, 1) : $urandom,
                      ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65280)
                                                  : $urandom_range(0, 3000));
            no_idle = (phase % 5 == 2);
            if (phase == 3)
            begin
                hold_request = 1'b1;
                write_reg(bsm_pkg::REG_FRAME_WIDTH, 2);
                write_reg(bsm_pkg::REG_FRAME_HEIGHT, 8);
            end
            repeat ($urandom_range(2, 4)) full_frame();
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 6)) scene_pixel(pixels_in, 1'b1);
                wait_idle();
                write_reg(bsm_pkg::REG_FRAME_WIDTH, 32'(width_reg));
            end
            no_idle = 1'b0;
            wait_idle();
            phase++;
        end
    endtask

    initial
    begin
        pix_in_bus.valid = 1'b0;
        pix_in_bus.mode = 1'b0;
        pix_in_bus.red_in = 8'd0;
        pix_in_bus.green_in = 8'd0;
        pix_in_bus.blue_in = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_size_extremes();
        test_midframe_resize();
        test_random();
        wait_idle();
        if (errors == 0 && expected_pixels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int            stall;
        pixel_result_t want;
        pix_out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                pix_out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_out_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pix_out_bus.valid);
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result rgb=%h%h%h fg=%b end=%b", $time,
                         pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out,
                         pix_out_bus.is_foreground, pix_out_bus.frame_end);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pix_out_bus.red_out !== want.red || pix_out_bus.green_out !== want.green
                    || pix_out_bus.blue_out !== want.blue
                    || pix_out_bus.is_foreground !== want.fg
                    || pix_out_bus.frame_end !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected rgb=%h%h%h fg=%b end=%b actual rgb=%h%h%h fg=%b end=%b",
                             $time, want.red, want.green, want.blue, want.fg, want.last,
                             pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out,
                             pix_out_bus.is_foreground, pix_out_bus.frame_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
endmodule

// File: sim.f
hdl/bsm_pkg.sv
hdl/bsm_if.sv
hdl/bsm_ram.sv
hdl/bsm_blend.sv
hdl/background_subtract_morph_mask.sv
sim/background_subtract_morph_mask_tb.sv
